@@ hw/rtl/lng_pkg.sv @@
// Shared constants and controller/datapath interface types for the lucky number generator.
`default_nettype none

package lng_pkg;

  // Fixed field widths.
  localparam int COUNT_W = 13;
  localparam int INDEX_W = 12;

  // Defaults for the top-level parameters.
  localparam int DEPTH_DEF      = 4096;
  localparam int VALUE_BITS_DEF = 24;

  // Reset value of the count limit register.
  localparam logic [COUNT_W-1:0] COUNT_RESET = 13'd4096;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;     // Take a request, apply restart.
    logic k_init;     // Load k with the current index.
    logic rd_top;     // Read the entry just above the top sieve position.
    logic top_cmp;    // Possibly raise the top sieve position, start the walk.
    logic rd_i;       // Read the sieve value at the walk position.
    logic dec_i;      // Skip this sieve value.
    logic div_start;  // Start k / (L - 1).
    logic k_upd;      // Fold the quotient into k and step down.
    logic fin;        // Form the result and store it in the table.
    logic set_done;   // Form a done result.
    logic out_load;   // Move the result into the output register.
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic n_done;     // Index has reached the limit.
    logic n_small;    // Index is 0 or 1.
    logic top_hit;    // Entry above top is at most n + 1.
    logic i_zero;     // Walk has reached position zero.
    logic l_small;    // Sieve value below two.
    logic div_done;   // Quotient is ready.
    logic out_free;   // Output register can take a result.
  } sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/lng_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lng_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

@@ hw/rtl/lng_div.sv @@
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none

module lng_div #(
  parameter int VB = 24
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [VB-1:0] dividend,
  input  wire logic [VB-1:0] divisor,
  output logic               done,
  output logic [VB-1:0]      quotient
);

  localparam int CW = $clog2(VB);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [VB-1:0] rem_r, rem_nxt;
  logic [VB-1:0] quo_r, quo_nxt;
  logic [VB-1:0] den_r, den_nxt;
  logic [VB:0]   trial;
  logic          fits;

  // One restoring step: shift in the next dividend bit and try a subtract.
  always_comb begin
    trial = {rem_r, quo_r[VB-1]};
    fits  = (trial >= {1'b0, den_r});
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      den_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? VB'(trial - {1'b0, den_r}) : trial[VB-1:0];
      quo_nxt = {quo_r[VB-2:0], fits};
      cnt_nxt = cnt_r + CW'(1);
      if (cnt_r == CW'(VB - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

@@ hw/rtl/lng_datapath.sv @@
// Datapath: index and sieve registers, sequence table, divider and output register.
`default_nettype none

module lng_datapath #(
  parameter int DEPTH = lng_pkg::DEPTH_DEF,
  parameter int VB    = lng_pkg::VALUE_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire lng_pkg::cmd_t                cmd,
  output lng_pkg::sts_t                     sts,
  input  wire logic                         in_restart,
  input  wire logic                         cfg_wr_en,
  input  wire logic [lng_pkg::COUNT_W-1:0]  cfg_wr_data,
  input  wire logic                         out_stall,
  output logic                              out_valid,
  output logic      [lng_pkg::INDEX_W-1:0]  out_index,
  output logic      [VB-1:0]                out_value,
  output logic                              out_done_res
);

  localparam int AW    = $clog2(DEPTH);
  localparam int IDX_W = $clog2(DEPTH + 1);
  localparam int CW    = VB + IDX_W + 1;
  localparam int LW    = IDX_W + lng_pkg::COUNT_W;
  localparam logic [VB-1:0] VMAX = {VB{1'b1}};
  localparam logic [VB-1:0] HALF = {1'b0, {(VB-1){1'b1}}};

  logic [lng_pkg::COUNT_W-1:0] count_limit_r, count_limit_nxt;
  logic [IDX_W-1:0]            next_index_r, next_index_nxt;
  logic [AW-1:0]               top_r, top_nxt;
  logic [AW-1:0]               i_r, i_nxt;
  logic [VB-1:0]               k_r, k_nxt;
  logic [VB-1:0]               res_value_r, res_value_nxt;
  logic                        res_done_r, res_done_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [lng_pkg::INDEX_W-1:0] out_index_r, out_index_nxt;
  logic [VB-1:0]               out_value_r, out_value_nxt;
  logic                        out_done_r, out_done_nxt;

  logic [VB-1:0]               rd_data;
  logic [AW-1:0]               rd_addr;
  logic [VB-1:0]               quotient;
  logic                        div_done;
  logic [VB-1:0]               fin_value;
  logic [IDX_W:0]              n_plus1;
  logic [LW-1:0]               n_wide;
  logic [LW-1:0]               lim_wide;
  logic [IDX_W+lng_pkg::INDEX_W-1:0] n_idx_ext;
  logic [VB+IDX_W-1:0]         n_k_ext;
  logic [VB:0]                 k_sum;

  // Sequence table.
  assign rd_addr = cmd.rd_top ? AW'(top_r + AW'(1)) : i_r;

  lng_ram #(
    .WIDTH (VB),
    .DEPTH (DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (cmd.fin),
    .wr_addr (next_index_r[AW-1:0]),
    .wr_data (fin_value),
    .rd_en   (cmd.rd_top | cmd.rd_i),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Divider for k / (L - 1).
  lng_div #(
    .VB (VB)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (k_r),
    .divisor  (rd_data - VB'(1)),
    .done     (div_done),
    .quotient (quotient)
  );

  // Widened copies of the index for compares and conversions.
  always_comb begin
    n_plus1   = {1'b0, next_index_r} + (IDX_W + 1)'(1);
    n_wide    = {{lng_pkg::COUNT_W{1'b0}}, next_index_r};
    lim_wide  = {{IDX_W{1'b0}}, count_limit_r};
    n_idx_ext = {{lng_pkg::INDEX_W{1'b0}}, next_index_r};
    n_k_ext   = {{VB{1'b0}}, next_index_r};
    k_sum     = {1'b0, k_r} + {1'b0, quotient};
  end

  // Status toward the controller.
  always_comb begin
    sts.n_done   = (n_wide >= lim_wide) || (n_wide >= LW'(DEPTH));
    sts.n_small  = (next_index_r < IDX_W'(2));
    sts.top_hit  = ({{(IDX_W+1){1'b0}}, rd_data} <= {{VB{1'b0}}, n_plus1});
    sts.i_zero   = (i_r == '0);
    sts.l_small  = (rd_data < VB'(2));
    sts.div_done = div_done;
    sts.out_free = !out_valid_r || !out_stall;
  end

  // Result value: fixed for the first two positions, otherwise 2k + 1 with saturation.
  always_comb begin
    if (sts.n_small) begin
      fin_value = next_index_r[0] ? VB'(3) : VB'(1);
    end else if (k_r >= HALF) begin
      fin_value = VMAX;
    end else begin
      fin_value = {k_r[VB-2:0], 1'b1};
    end
  end

  // Next-state logic for the working registers.
  always_comb begin
    count_limit_nxt = count_limit_r;
    next_index_nxt  = next_index_r;
    top_nxt         = top_r;
    i_nxt           = i_r;
    k_nxt           = k_r;
    res_value_nxt   = res_value_r;
    res_done_nxt    = res_done_r;

    if (cfg_wr_en) begin
      count_limit_nxt = cfg_wr_data;
    end

    // Restart clears the position before the request is worked on.
    if (cmd.accept && in_restart) begin
      next_index_nxt = '0;
      top_nxt        = '0;
    end

    if (cmd.k_init) begin
      k_nxt = n_k_ext[VB-1:0];
    end

    // The top sieve position grows by at most one per request.
    if (cmd.top_cmp) begin
      if (sts.top_hit) begin
        top_nxt = top_r + AW'(1);
        i_nxt   = top_r + AW'(1);
      end else begin
        i_nxt = top_r;
      end
    end

    if (cmd.dec_i) begin
      i_nxt = i_r - AW'(1);
    end

    // k = k + k / (L - 1), saturated.
    if (cmd.k_upd) begin
      k_nxt = k_sum[VB] ? VMAX : k_sum[VB-1:0];
      i_nxt = i_r - AW'(1);
    end

    if (cmd.fin) begin
      res_value_nxt = fin_value;
      res_done_nxt  = 1'b0;
    end

    if (cmd.set_done) begin
      res_value_nxt = '0;
      res_done_nxt  = 1'b1;
    end

    // Position advances once the produced value is handed over.
    if (cmd.out_load && !res_done_r) begin
      next_index_nxt = next_index_r + IDX_W'(1);
    end
  end

  // Output register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_index_nxt = out_index_r;
    out_value_nxt = out_value_r;
    out_done_nxt  = out_done_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
      out_index_nxt = res_done_r ? '0 : n_idx_ext[lng_pkg::INDEX_W-1:0];
      out_value_nxt = res_value_r;
      out_done_nxt  = res_done_r;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_limit_r <= lng_pkg::COUNT_RESET;
      next_index_r  <= '0;
      top_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      count_limit_r <= count_limit_nxt;
      next_index_r  <= next_index_nxt;
      top_r         <= top_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r         <= i_nxt;
    k_r         <= k_nxt;
    res_value_r <= res_value_nxt;
    res_done_r  <= res_done_nxt;
    out_index_r <= out_index_nxt;
    out_value_r <= out_value_nxt;
    out_done_r  <= out_done_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_index    = out_index_r;
  assign out_value    = out_value_r;
  assign out_done_res = out_done_r;

endmodule

`default_nettype wire

@@ hw/rtl/lng_ctrl.sv @@
// Controller state machine that sequences the sieve walk for each request.
`default_nettype none

module lng_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire lng_pkg::sts_t sts,
  output lng_pkg::cmd_t      cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_TOPCMP = 3'd2;
  localparam logic [2:0] S_RD     = 3'd3;
  localparam logic [2:0] S_LD     = 3'd4;
  localparam logic [2:0] S_DIV    = 3'd5;
  localparam logic [2:0] S_FIN    = 3'd6;
  localparam logic [2:0] S_OUT    = 3'd7;

  logic [2:0] state_r, state_nxt;

  // Requests are taken only between items.
  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.n_done) begin
          cmd.set_done = 1'b1;
          state_nxt    = S_OUT;
        end else if (sts.n_small) begin
          state_nxt = S_FIN;
        end else begin
          cmd.k_init = 1'b1;
          cmd.rd_top = 1'b1;
          state_nxt  = S_TOPCMP;
        end
      end
      S_TOPCMP: begin
        cmd.top_cmp = 1'b1;
        state_nxt   = S_RD;
      end
      // Walk the sieve values from the top position down to position one.
      S_RD: begin
        if (sts.i_zero) begin
          state_nxt = S_FIN;
        end else begin
          cmd.rd_i  = 1'b1;
          state_nxt = S_LD;
        end
      end
      S_LD: begin
        if (sts.l_small) begin
          cmd.dec_i = 1'b1;
          state_nxt = S_RD;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.k_upd = 1'b1;
          state_nxt = S_RD;
        end
      end
      S_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // An accepted request always goes to the limit check next.
  a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_CHECK))
    else $error("accepted request did not reach the limit check");

  // The result is only moved when the output register can take it.
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free)
    else $error("output register overwritten");

  // The table port serves one purpose per cycle.
  a_port_single: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.rd_top, cmd.rd_i, cmd.fin}))
    else $error("table port used twice in one cycle");

  // A finished division always resumes the walk.
  a_div_resume: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && sts.div_done) |=> (state_r == S_RD))
    else $error("walk did not resume after division");

endmodule

`default_nettype wire

@@ hw/rtl/lucky_number_generator_core.sv @@
// Lucky number generator: top level joining the controller and the datapath.
//
// Each request on the input channel (in_valid / in_stall, field in_restart)
// asks for the next lucky number 1, 3, 7, 9, 13, ...; in_restart set starts
// again at position 0. Each request yields one result on the output channel
// (out_valid / out_stall): out_index, out_value and out_done_res. Once
// cfg_wr_data (written with cfg_wr_en while idle) values have been produced,
// results carry out_done_res set with index and value zero.
// For a later position the controller walks the earlier sieve values from the
// top down; each costs a table read, a check and, for a value of two or more,
// a run of the shared bit-serial divider. One request is worked on at a time,
// and the next is taken in the cycle after the result is loaded.
// The output register holds a finished result while out_stall is high; the
// next request is taken meanwhile and waits for it before it is delivered.
// Reset clears the position, the sieve top and the limit (to 4096); the
// table needs no clearing and is read only where it was already written.
`default_nettype none

module lucky_number_generator_core #(
  parameter int DEPTH      = lng_pkg::DEPTH_DEF,
  parameter int VALUE_BITS = lng_pkg::VALUE_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        in_restart,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic     [lng_pkg::INDEX_W-1:0]  out_index,
  output logic     [VALUE_BITS-1:0]        out_value,
  output logic                             out_done_res,
  input  wire logic                        cfg_wr_en,
  input  wire logic [lng_pkg::COUNT_W-1:0] cfg_wr_data
);

  lng_pkg::cmd_t cmd;
  lng_pkg::sts_t sts;

  lng_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  lng_datapath #(
    .DEPTH (DEPTH),
    .VB    (VALUE_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_restart   (in_restart),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .out_index    (out_index),
    .out_value    (out_value),
    .out_done_res (out_done_res)
  );

endmodule

`default_nettype wire
